>>> sv/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers clocked on i_clk.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check only while out of reset.
`define ASSERT_RST(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) prop) else $error(msg);

// Check at every edge, reset included.
`define ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge i_clk) prop) else $error(msg);

`endif

>>> sv/adcseq_pkg.sv
// ----------------------------------------------------------------------------
// adcseq_pkg
// Types and constants shared by the ADC sequencer and its adder.
// ----------------------------------------------------------------------------
`default_nettype none

package adcseq_pkg;

    localparam int IN_DATA_W  = 40;
    localparam int OUT_DATA_W = 32;
    localparam int OUT_USER_W = 3;

    // Item kind on the input tuser bit
    localparam logic CMD_START = 1'b0;
    localparam logic CMD_CYCLE = 1'b1;

    // Bus cycle counter within one instruction
    localparam logic [2:0] STEP_IDLE = 3'd0;
    localparam logic [2:0] STEP_1    = 3'd1;
    localparam logic [2:0] STEP_2    = 3'd2;
    localparam logic [2:0] STEP_3    = 3'd3;
    localparam logic [2:0] STEP_4    = 3'd4;
    localparam logic [2:0] STEP_5    = 3'd5;

    // Decimal adjust constants
    localparam logic [5:0] BCD_DIGIT_MAX = 6'h09;
    localparam logic [5:0] BCD_DIGIT_FIX = 6'h06;
    localparam logic [5:0] BCD_NIB_MAX   = 6'h0F;
    localparam logic [9:0] BCD_HALF_CY   = 10'h010;
    localparam logic [9:0] BCD_HIGH_MAX  = 10'h09F;
    localparam logic [9:0] BCD_HIGH_FIX  = 10'h060;

    typedef enum logic [2:0] {
        MODE_IMM  = 3'd0,
        MODE_ZP   = 3'd1,
        MODE_ZPX  = 3'd2,
        MODE_ABS  = 3'd3,
        MODE_ABSX = 3'd4,
        MODE_ABSY = 3'd5,
        MODE_INDX = 3'd6,
        MODE_INDY = 3'd7
    } t_mode;

    // Input tdata, last field (mode) in the low bits
    typedef struct packed {
        logic [2:0] pad;
        logic       decimal_in;
        logic       carry_in;
        logic [7:0] index_y;
        logic [7:0] index_x;
        logic [7:0] acc_in;
        logic [7:0] read_data;
        t_mode      mode;
    } t_in_data;

    typedef struct packed {
        logic [3:0]  pad;
        logic        flag_n;
        logic        flag_v;
        logic        flag_z;
        logic        flag_c;
        logic [7:0]  acc_out;
        logic [15:0] read_addr;
    } t_out_data;

    typedef struct packed {
        logic done_res;
        logic read_from_pc;
        logic read_request;
    } t_out_user;

    typedef struct packed {
        logic [7:0] acc;
        logic [7:0] opnd;
        logic       carry;
        logic       bcd;
    } t_alu_in;

    typedef struct packed {
        logic [7:0] acc;
        logic       flag_c;
        logic       flag_z;
        logic       flag_v;
        logic       flag_n;
    } t_alu_res;

endpackage

`default_nettype wire

>>> sv/adcseq_alu.sv
// ----------------------------------------------------------------------------
// adcseq_alu
// Binary and decimal add with carry, producing the new accumulator and flags.
// ----------------------------------------------------------------------------
`default_nettype none

module adcseq_alu (
    input  adcseq_pkg::t_alu_in  i_alu,
    output adcseq_pkg::t_alu_res o_alu
);
    import adcseq_pkg::*;

    logic [4:0] w_lo_raw;
    logic [5:0] w_lo_adj;
    logic [9:0] w_dec;
    logic [9:0] w_bin;
    logic [9:0] w_sum;
    logic [9:0] w_fin;

    always_comb begin
        w_lo_raw = {1'b0, i_alu.opnd[3:0]} + {1'b0, i_alu.acc[3:0]} + {4'b0, i_alu.carry};
        w_lo_adj = ({1'b0, w_lo_raw} > BCD_DIGIT_MAX) ? ({1'b0, w_lo_raw} + BCD_DIGIT_FIX)
                                                      : {1'b0, w_lo_raw};
        // high digits, the adjusted low digit and its carry; in decimal mode V is taken from this sum
        w_dec = {2'b0, i_alu.opnd[7:4], 4'b0} + {2'b0, i_alu.acc[7:4], 4'b0}
              + ((w_lo_adj > BCD_NIB_MAX) ? BCD_HALF_CY : 10'h000)
              + {6'b0, w_lo_adj[3:0]};
        w_bin = {2'b0, i_alu.opnd} + {2'b0, i_alu.acc} + {9'b0, i_alu.carry};
        w_sum = i_alu.bcd ? w_dec : w_bin;
        w_fin = (i_alu.bcd && (w_sum > BCD_HIGH_MAX)) ? (w_sum + BCD_HIGH_FIX) : w_sum;

        o_alu.acc    = w_fin[7:0];
        o_alu.flag_c = |w_fin[9:8];
        o_alu.flag_z = (w_fin[7:0] == 8'h00);
        o_alu.flag_v = ~(i_alu.acc[7] ^ i_alu.opnd[7]) & (i_alu.acc[7] ^ w_sum[7]);
        o_alu.flag_n = w_fin[7];
    end

endmodule

`default_nettype wire

>>> sv/adc_addressing_sequencer_bcd_unit.sv
// ----------------------------------------------------------------------------
// adc_addressing_sequencer_bcd_unit
// 6502 ADC executor stepped one bus cycle per input word.
// ----------------------------------------------------------------------------
// Usage:
//   Slave channel (i_s_*): tuser is the command. A start word latches mode,
//   A, X, Y, carry and decimal flag and begins a new instruction, abandoning
//   any running one. A cycle word carries the byte read for the previous
//   request. Cycle words while idle give an all-zero result.
//   Master channel (o_m_*): exactly one result word per input word: a read at
//   PC, a read at a formed address, an idle bus cycle, or completion with the
//   new accumulator and C, Z, V, N.
//   Each word passes an input register and then a result register on its
//   way to the master side.
//   Throughput: one word per cycle while results are taken; the address
//   sequencer, 16-bit index add and decimal adder all sit between the two registers.
//   Reset empties both registers and returns the sequencer to idle.
//   A stall on the master side holds the result register; the input register
//   then fills and tready drops until the result is taken.
// ----------------------------------------------------------------------------
`default_nettype none

module adc_addressing_sequencer_bcd_unit (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_s_tvalid,
    output logic                                o_s_tready,
    // mode, read_data, acc_in, index_x, index_y, carry_in, decimal_in, zero pad
    input  logic [adcseq_pkg::IN_DATA_W-1:0]    i_s_tdata,
    // cmd
    input  logic                                i_s_tuser,
    output logic                                o_m_tvalid,
    input  logic                                i_m_tready,
    // read_addr, acc_out, flag_c, flag_z, flag_v, flag_n, zero pad
    output logic [adcseq_pkg::OUT_DATA_W-1:0]   o_m_tdata,
    // read_request, read_from_pc, done_res
    output logic [adcseq_pkg::OUT_USER_W-1:0]   o_m_tuser
);
    import adcseq_pkg::*;

    `include "assert_macros.svh"

    // input register
    logic      r_in_vld;
    logic      r_in_cmd;
    t_in_data  r_in_data;

    // result register
    logic      r_out_vld;
    t_out_data r_out_data;
    t_out_user r_out_user;

    // instruction state
    logic [2:0]  r_step,     n_step;
    t_mode       r_mode,     n_mode;
    logic [7:0]  r_zp,       n_zp;
    logic [15:0] r_eff,      n_eff;
    logic [7:0]  r_acc,      n_acc;
    logic [7:0]  r_x,        n_x;
    logic [7:0]  r_y,        n_y;
    logic        r_carry,    n_carry;
    logic        r_bcd,      n_bcd;

    logic        w_accept;
    logic        w_adv;
    t_out_data   w_res_data;
    t_out_user   w_res_user;
    t_alu_in     w_alu_in;
    t_alu_res    w_alu_res;
    logic [7:0]  w_d;
    logic [15:0] w_base;
    logic [15:0] w_idx_sum;
    logic [7:0]  w_idx;
    logic        w_same_page;
    logic        w_finish;

    assign w_adv      = r_in_vld && (!r_out_vld || i_m_tready);
    assign o_s_tready = !r_in_vld || w_adv;
    assign w_accept   = i_s_tvalid && o_s_tready;

    assign w_d      = r_in_data.read_data;
    assign w_alu_in = '{acc: r_acc, opnd: w_d, carry: r_carry, bcd: r_bcd};

    adcseq_alu u_alu (
        .i_alu (w_alu_in),
        .o_alu (w_alu_res)
    );

    // absolute and indirect forms: high byte arrives now, low byte already in r_eff
    assign w_base      = {w_d, r_eff[7:0]};
    assign w_idx       = (r_mode == MODE_ABSX) ? r_x : r_y;
    assign w_idx_sum   = w_base + {8'h00, w_idx};
    assign w_same_page = (w_base[15:8] == w_idx_sum[15:8]);

    always_comb begin
        n_step   = r_step;
        n_mode   = r_mode;
        n_zp     = r_zp;
        n_eff    = r_eff;
        n_acc    = r_acc;
        n_x      = r_x;
        n_y      = r_y;
        n_carry  = r_carry;
        n_bcd    = r_bcd;
        w_res_data = '0;
        w_res_user = '0;
        w_finish   = 1'b0;

        if (r_in_cmd == CMD_START) begin
            n_mode  = r_in_data.mode;
            n_acc   = r_in_data.acc_in;
            n_x     = r_in_data.index_x;
            n_y     = r_in_data.index_y;
            n_carry = r_in_data.carry_in;
            n_bcd   = r_in_data.decimal_in;
            n_zp    = 8'h00;
            n_eff   = 16'h0000;
            n_step  = STEP_1;
            w_res_user.read_request = 1'b1;
            w_res_user.read_from_pc = 1'b1;
        end else if (r_step != STEP_IDLE) begin
            n_step = r_step + 3'd1;
            case (r_mode)
                MODE_IMM: begin
                    w_finish = 1'b1;
                end
                MODE_ZP: begin
                    if (r_step == STEP_1) begin
                        n_zp = w_d;
                        w_res_user.read_request = 1'b1;
                        w_res_data.read_addr    = {8'h00, w_d};
                    end else begin
                        w_finish = 1'b1;
                    end
                end
                MODE_ZPX: begin
                    if (r_step == STEP_1) begin
                        n_zp = w_d + r_x;
                    end else if (r_step == STEP_2) begin
                        w_res_user.read_request = 1'b1;
                        w_res_data.read_addr    = {8'h00, r_zp};
                    end else begin
                        w_finish = 1'b1;
                    end
                end
                MODE_ABS: begin
                    if (r_step == STEP_1) begin
                        n_eff = {8'h00, w_d};
                        w_res_user.read_request = 1'b1;
                        w_res_user.read_from_pc = 1'b1;
                    end else if (r_step == STEP_2) begin
                        n_eff = w_base;
                        w_res_user.read_request = 1'b1;
                        w_res_data.read_addr    = w_base;
                    end else begin
                        w_finish = 1'b1;
                    end
                end
                MODE_ABSX, MODE_ABSY: begin
                    if (r_step == STEP_1) begin
                        n_eff = {8'h00, w_d};
                        w_res_user.read_request = 1'b1;
                        w_res_user.read_from_pc = 1'b1;
                    end else if (r_step == STEP_2) begin
                        n_eff = w_idx_sum;
                        // spend an idle cycle on a page crossing
                        if (w_same_page) begin
                            n_step = STEP_4;
                            w_res_user.read_request = 1'b1;
                            w_res_data.read_addr    = w_idx_sum;
                        end else begin
                            n_step = STEP_3;
                        end
                    end else if (r_step == STEP_3) begin
                        w_res_user.read_request = 1'b1;
                        w_res_data.read_addr    = r_eff;
                    end else begin
                        w_finish = 1'b1;
                    end
                end
                MODE_INDX: begin
                    if (r_step == STEP_1) begin
                        n_zp = w_d + r_x;
                    end else if (r_step == STEP_2) begin
                        n_zp = r_zp + 8'h01;
                        w_res_user.read_request = 1'b1;
                        w_res_data.read_addr    = {8'h00, r_zp};
                    end else if (r_step == STEP_3) begin
                        n_eff = {8'h00, w_d};
                        w_res_user.read_request = 1'b1;
                        w_res_data.read_addr    = {8'h00, r_zp};
                    end else if (r_step == STEP_4) begin
                        n_eff = w_base;
                        w_res_user.read_request = 1'b1;
                        w_res_data.read_addr    = w_base;
                    end else begin
                        w_finish = 1'b1;
                    end
                end
                MODE_INDY: begin
                    if (r_step == STEP_1) begin
                        n_zp = w_d + 8'h01;
                        w_res_user.read_request = 1'b1;
                        w_res_data.read_addr    = {8'h00, w_d};
                    end else if (r_step == STEP_2) begin
                        n_eff = {8'h00, w_d};
                        w_res_user.read_request = 1'b1;
                        w_res_data.read_addr    = {8'h00, r_zp};
                    end else if (r_step == STEP_3) begin
                        n_eff = w_idx_sum;
                        if (w_same_page) begin
                            n_step = STEP_5;
                            w_res_user.read_request = 1'b1;
                            w_res_data.read_addr    = w_idx_sum;
                        end else begin
                            n_step = STEP_4;
                        end
                    end else if (r_step == STEP_4) begin
                        w_res_user.read_request = 1'b1;
                        w_res_data.read_addr    = r_eff;
                    end else begin
                        w_finish = 1'b1;
                    end
                end
                default: begin
                    w_finish = 1'b1;
                end
            endcase

            if (w_finish) begin
                n_step = STEP_IDLE;
                w_res_user.done_res = 1'b1;
                w_res_data.acc_out  = w_alu_res.acc;
                w_res_data.flag_c   = w_alu_res.flag_c;
                w_res_data.flag_z   = w_alu_res.flag_z;
                w_res_data.flag_v   = w_alu_res.flag_v;
                w_res_data.flag_n   = w_alu_res.flag_n;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_vld  <= 1'b0;
            r_out_vld <= 1'b0;
            r_step    <= STEP_IDLE;
        end else begin
            if (w_accept) begin
                r_in_vld <= 1'b1;
            end else if (w_adv) begin
                r_in_vld <= 1'b0;
            end
            if (w_adv) begin
                r_out_vld <= 1'b1;
                r_step    <= n_step;
            end else if (i_m_tready) begin
                r_out_vld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_in_cmd  <= i_s_tuser;
            r_in_data <= t_in_data'(i_s_tdata);
        end
        if (w_adv) begin
            r_out_data <= w_res_data;
            r_out_user <= w_res_user;
            r_mode     <= n_mode;
            r_zp       <= n_zp;
            r_eff      <= n_eff;
            r_acc      <= n_acc;
            r_x        <= n_x;
            r_y        <= n_y;
            r_carry    <= n_carry;
            r_bcd      <= n_bcd;
        end
    end

    assign o_m_tvalid = r_out_vld;
    assign o_m_tdata  = r_out_data;
    assign o_m_tuser  = r_out_user;

    `ASSERT_ALWAYS(a_rst_empty, !i_rst_n |=> (!r_in_vld && !r_out_vld), "pipeline not empty after reset")
    `ASSERT_RST(a_done_idle, (w_adv && w_res_user.done_res) |=> (r_step == STEP_IDLE), "step not idle after completion")
    `ASSERT_RST(a_step_range, r_step <= STEP_5, "step counter out of range")

endmodule

`default_nettype wire
